// ===== rtl/core/mtw_pkg.sv =====
// Shared types and codes for the two-level table walker.
// No dependencies; imported by every module of the block.
`default_nettype none

package mtw_pkg;

   localparam int unsigned TableBaseWidth = 18;
   localparam int unsigned RomSysWidth    = 2;
   localparam int unsigned CsrIndexWidth  = 2;
   localparam int unsigned CsrDataWidth   = 18;

   localparam logic [CsrIndexWidth-1:0] CSR_TABLE_BASE = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ROM_SYS    = 2'd1;

   localparam logic FUNC_REQUEST    = 1'b0;
   localparam logic FUNC_DESCRIPTOR = 1'b1;

   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_IGNORED = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      FK_NONE      = 3'd0,
      FK_SEC_XLAT  = 3'd1,
      FK_PAGE_XLAT = 3'd2,
      FK_SEC_PERM  = 3'd3,
      FK_PAGE_PERM = 3'd4,
      FK_TINY      = 3'd5
   } fault_kind_type;

   // Descriptor type field, bits 1:0.
   localparam logic [1:0] DESC_FAULT   = 2'd0;
   localparam logic [1:0] DESC_COARSE  = 2'd1;
   localparam logic [1:0] DESC_SECTION = 2'd2;
   localparam logic [1:0] DESC_FINE    = 2'd3;
   localparam logic [1:0] DESC_LARGE   = 2'd1;
   localparam logic [1:0] DESC_SMALL   = 2'd2;

   typedef struct packed {
      logic        func;
      logic [31:0] vaddr;
      logic        is_write;
      logic        privileged;
      logic [31:0] descriptor;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] read_addr;
      logic [31:0] phys_addr;
      logic        fault;
      logic [2:0]  fault_kind;
   } rsp_item_type;

   typedef struct packed {
      logic [TableBaseWidth-1:0] table_base;
      logic [RomSysWidth-1:0]    rom_sys_bits;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/mtw_walker.sv =====
// Walk state and descriptor decode: holds the phase and the pending request,
// and turns one transaction into its result. Depends on mtw_pkg.
`default_nettype none

module mtw_walker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire mtw_pkg::req_item_type item,
   input  wire mtw_pkg::cfg_type      cfg,
   output mtw_pkg::rsp_item_type      result
);
   import mtw_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_L1   = 2'd1,
      PH_L2   = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] pend_vaddr_ff;
   logic        pend_write_ff;
   logic        pend_priv_ff;

   logic [31:0]    d;
   logic [31:0]    va;
   logic [1:0]     sub_ap;
   logic [1:0]     sub_idx;
   fault_kind_type fk;

   // AP zero with S and R both set behaves as privileged-only access.
   function automatic logic access_ok(input logic [1:0] ap, input logic [1:0] rs,
                                      input logic wr, input logic priv);
      logic ok;
      ok = 1'b0;
      case (ap)
         2'd0: begin
            if (rs == 2'b11) ok = priv;
            else if (wr) ok = 1'b0;
            else if (rs[1]) ok = 1'b1;
            else if (rs[0]) ok = priv;
            else ok = 1'b0;
         end
         2'd1: ok = priv;
         2'd2: ok = priv | ~wr;
         default: ok = 1'b1;
      endcase
      return ok;
   endfunction

   assign d  = item.descriptor;
   assign va = pend_vaddr_ff;

   // Large pages pick the subpage from va[15:14], small pages from va[11:10].
   assign sub_idx = (d[1:0] == DESC_LARGE) ? va[15:14] : va[11:10];

   always_comb begin
      case (sub_idx)
         2'd0:    sub_ap = d[5:4];
         2'd1:    sub_ap = d[7:6];
         2'd2:    sub_ap = d[9:8];
         default: sub_ap = d[11:10];
      endcase
   end

   always_comb begin
      phase_in           = phase_ff;
      fk                 = FK_NONE;
      result.result_kind = KIND_IGNORED;
      result.read_addr   = 32'd0;
      result.phys_addr   = 32'd0;
      if (item.func == FUNC_REQUEST) begin
         phase_in           = PH_L1;
         result.result_kind = KIND_READ;
         result.read_addr   = {cfg.table_base, item.vaddr[31:20], 2'b00};
      end else begin
         unique case (phase_ff)
            PH_L1: begin
               phase_in           = PH_IDLE;
               result.result_kind = KIND_DONE;
               case (d[1:0])
                  DESC_FAULT: fk = FK_SEC_XLAT;
                  DESC_COARSE: begin
                     phase_in           = PH_L2;
                     result.result_kind = KIND_READ;
                     result.read_addr   = {d[31:10], va[19:12], 2'b00};
                  end
                  DESC_SECTION: begin
                     if (access_ok(d[11:10], cfg.rom_sys_bits, pend_write_ff, pend_priv_ff))
                        result.phys_addr = {d[31:20], va[19:0]};
                     else
                        fk = FK_SEC_PERM;
                  end
                  default: fk = FK_TINY;
               endcase
            end
            PH_L2: begin
               phase_in           = PH_IDLE;
               result.result_kind = KIND_DONE;
               case (d[1:0])
                  DESC_FAULT: fk = FK_PAGE_XLAT;
                  DESC_LARGE: begin
                     if (access_ok(sub_ap, cfg.rom_sys_bits, pend_write_ff, pend_priv_ff))
                        result.phys_addr = {d[31:16], va[15:0]};
                     else
                        fk = FK_PAGE_PERM;
                  end
                  DESC_SMALL: begin
                     if (access_ok(sub_ap, cfg.rom_sys_bits, pend_write_ff, pend_priv_ff))
                        result.phys_addr = {d[31:12], va[11:0]};
                     else
                        fk = FK_PAGE_PERM;
                  end
                  default: fk = FK_TINY;
               endcase
            end
            default: begin
               result.result_kind = KIND_IGNORED;
            end
         endcase
      end
      result.fault      = (fk != FK_NONE);
      result.fault_kind = fk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         pend_vaddr_ff <= 32'd0;
         pend_write_ff <= 1'b0;
         pend_priv_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         if (item.func == FUNC_REQUEST) begin
            pend_vaddr_ff <= item.vaddr;
            pend_write_ff <= item.is_write;
            pend_priv_ff  <= item.privileged;
         end
      end
   end

   a_request_starts_walk: assert property (@(posedge clock) disable iff (reset)
      step && item.func == FUNC_REQUEST |=> phase_ff == PH_L1)
      else $error("request did not restart the walk at the first level");

   a_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      step && result.result_kind == KIND_DONE |=> phase_ff == PH_IDLE)
      else $error("walk still active after a finished translation");

   a_ignored_only_idle: assert property (@(posedge clock) disable iff (reset)
      step && result.result_kind == KIND_IGNORED |-> phase_ff == PH_IDLE
         && result.read_addr == 32'd0 && !result.fault)
      else $error("descriptor ignored while a walk was active");

   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff))
      else $error("walk phase moved without a transaction");

   a_fault_no_paddr: assert property (@(posedge clock) disable iff (reset)
      step && result.fault |-> result.phys_addr == 32'd0
         && result.result_kind == KIND_DONE)
      else $error("faulting translation carries an address");

endmodule

`default_nettype wire

// ===== rtl/core/mmu_two_level_table_walk.sv =====
// Top level of the two-level table walker: input register, config registers,
// walker and result register. Depends on mtw_pkg and mtw_walker.
//
//   channel | direction | handshake               | payload
//   req_    | in        | req_valid / req_ready   | req_item (mtw_pkg::req_item_type)
//   rsp_    | out       | rsp_valid / rsp_ready   | rsp_item (mtw_pkg::rsp_item_type)
//   csr_    | in        | csr_valid / csr_ready   | csr_index, csr_wdata
//
// One transaction per cycle while rsp_ is not stalled; each accepted transaction
// is decoded by the walker as it leaves the input register, and its result is
// registered in the result register and offered on rsp_. The walk phase is
// updated when a transaction leaves the input register, so a stalled result
// stalls the input register, which in turn drops req_ready. Reset clears the
// walk, both valid flags and the config registers; csr_ready is always high.
`default_nettype none

module mmu_two_level_table_walk (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire mtw_pkg::req_item_type             req_item,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output mtw_pkg::rsp_item_type                  rsp_item,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mtw_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [mtw_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import mtw_pkg::*;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   cfg_type      cfg_ff;
   rsp_item_type result;
   logic         out_free;
   logic         step;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   mtw_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (out_free) out_valid_ff <= step;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TABLE_BASE: cfg_ff.table_base   <= csr_wdata[TableBaseWidth-1:0];
               CSR_ROM_SYS:    cfg_ff.rom_sys_bits <= csr_wdata[RomSysWidth-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_item_ff <= req_item;
      if (step) out_item_ff <= result;
   end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mmu_two_level_table_walk: table walks with directed and random
// descriptors, checked against a behavioral walk predictor. Depends on mtw_pkg and the RTL.

module tb_top;
   import mtw_pkg::*;

   localparam int QuietLimit = 2000;
   localparam int IdlePct    = 18;

   // Index values that decode to no register; writes to them must be dropped.
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_B = 2'd3;

   // Access permission codes and the positions of the R and S control bits.
   localparam logic [1:0] AP_NONE      = 2'd0;
   localparam logic [1:0] AP_PRIV      = 2'd1;
   localparam logic [1:0] AP_USER_READ = 2'd2;
   localparam logic [1:0] AP_FULL      = 2'd3;
   localparam int         ROM_BIT      = 1;
   localparam int         SYS_BIT      = 0;

   typedef enum logic [1:0] {
      WALK_IDLE = 2'd0,
      WALK_L1   = 2'd1,
      WALK_L2   = 2'd2
   } walk_phase_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_item_type             req_item  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_item_type             rsp_item;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   req_item_type req_backlog[$];
   rsp_item_type rsp_due[$];
   int           send_idle_pct = IdlePct;
   int           recv_idle_pct = IdlePct;
   int           rsp_stall_left = 0;
   int           fail_count = 0;
   int           quiet_cycles = 0;

   // Walk predictor state and its copy of the registers.
   walk_phase_type              tw_phase;
   logic [31:0]                 held_vaddr;
   logic                        held_write;
   logic                        held_priv;
   logic [TableBaseWidth-1:0]   cfg_table_base;
   logic [RomSysWidth-1:0]      cfg_rom_sys;

   mmu_two_level_table_walk u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic access_ok(logic [1:0] ap, logic [1:0] rs, logic wr, logic priv);
      case (ap)
         AP_NONE: begin
            // With both R and S set, an AP of zero behaves like privileged-only.
            if (rs[ROM_BIT] && rs[SYS_BIT]) return priv;
            if (wr) return 1'b0;
            if (rs[ROM_BIT]) return 1'b1;
            if (rs[SYS_BIT]) return priv;
            return 1'b0;
         end
         AP_PRIV:      return priv;
         AP_USER_READ: return priv || !wr;
         default:      return 1'b1;
      endcase
   endfunction

   function automatic rsp_item_type walk_done(fault_kind_type fk, logic [31:0] pa);
      rsp_item_type r;
      r = '0;
      r.result_kind = KIND_DONE;
      r.phys_addr   = pa;
      r.fault       = (fk != FK_NONE);
      r.fault_kind  = fk;
      return r;
   endfunction

   task automatic predict_walk(input req_item_type it);
      rsp_item_type r;
      logic [31:0]  d;
      logic [31:0]  va;
      logic [1:0]   ap;
      int           sub;
      r  = '0;
      d  = it.descriptor;
      va = held_vaddr;
      if (it.func == FUNC_REQUEST) begin
         // A new request always restarts at the first level.
         held_vaddr    = it.vaddr;
         held_write    = it.is_write;
         held_priv     = it.privileged;
         tw_phase      = WALK_L1;
         r.result_kind = KIND_READ;
         r.read_addr   = {cfg_table_base, it.vaddr[31:20], 2'b00};
      end else if (tw_phase == WALK_L1) begin
         tw_phase = WALK_IDLE;
         case (d[1:0])
            DESC_FAULT: r = walk_done(FK_SEC_XLAT, 32'd0);
            DESC_COARSE: begin
               tw_phase      = WALK_L2;
               r.result_kind = KIND_READ;
               r.read_addr   = {d[31:10], va[19:12], 2'b00};
            end
            DESC_SECTION: begin
               if (access_ok(d[11:10], cfg_rom_sys, held_write, held_priv))
                  r = walk_done(FK_NONE, {d[31:20], va[19:0]});
               else
                  r = walk_done(FK_SEC_PERM, 32'd0);
            end
            default: r = walk_done(FK_TINY, 32'd0);
         endcase
      end else if (tw_phase == WALK_L2) begin
         tw_phase = WALK_IDLE;
         case (d[1:0])
            DESC_FAULT: r = walk_done(FK_PAGE_XLAT, 32'd0);
            DESC_LARGE: begin
               sub = int'(va[15:14]);
               ap  = d[4 + 2 * sub +: 2];
               if (access_ok(ap, cfg_rom_sys, held_write, held_priv))
                  r = walk_done(FK_NONE, {d[31:16], va[15:0]});
               else
                  r = walk_done(FK_PAGE_PERM, 32'd0);
            end
            DESC_SMALL: begin
               sub = int'(va[11:10]);
               ap  = d[4 + 2 * sub +: 2];
               if (access_ok(ap, cfg_rom_sys, held_write, held_priv))
                  r = walk_done(FK_NONE, {d[31:12], va[11:0]});
               else
                  r = walk_done(FK_PAGE_PERM, 32'd0);
            end
            default: r = walk_done(FK_TINY, 32'd0);
         endcase
      end else begin
         r.result_kind = KIND_IGNORED;
      end
      rsp_due.push_back(r);
   endtask

   // Driver: offers the oldest pending item and feeds every accepted transaction to the predictor.
   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         tw_phase       = WALK_IDLE;
         held_vaddr     = '0;
         held_write     = 1'b0;
         held_priv      = 1'b0;
         cfg_table_base = '0;
         cfg_rom_sys    = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TABLE_BASE: cfg_table_base = csr_wdata[TableBaseWidth-1:0];
               CSR_ROM_SYS:    cfg_rom_sys    = csr_wdata[RomSysWidth-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_walk(req_item);
            void'(req_backlog.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_item  <= req_backlog[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: every result transaction is matched against the oldest prediction.
   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_due.size() == 0) begin
            $error("result_kind: expected none, actual %0h", rsp_item.result_kind);
            fail_count++;
         end else begin
            want = rsp_due.pop_front();
            check_field("result_kind", 32'(want.result_kind), 32'(rsp_item.result_kind));
            check_field("read_addr", want.read_addr, rsp_item.read_addr);
            check_field("phys_addr", want.phys_addr, rsp_item.phys_addr);
            check_field("fault", 32'(want.fault), 32'(rsp_item.fault));
            check_field("fault_kind", 32'(want.fault_kind), 32'(rsp_item.fault_kind));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_item_type walk_request(logic [31:0] va, logic wr, logic priv);
      req_item_type it;
      it.func       = FUNC_REQUEST;
      it.vaddr      = va;
      it.is_write   = wr;
      it.privileged = priv;
      it.descriptor = $urandom();
      return it;
   endfunction

   function automatic req_item_type table_word(logic [31:0] d);
      req_item_type it;
      it.func       = FUNC_DESCRIPTOR;
      it.vaddr      = $urandom();
      it.is_write   = 1'($urandom_range(1));
      it.privileged = 1'($urandom_range(1));
      it.descriptor = d;
      return it;
   endfunction

   // Random descriptor of the given type with every AP field set to ap.
   function automatic logic [31:0] perm_word(logic [1:0] kind, logic [1:0] ap);
      logic [31:0] raw;
      raw       = $urandom();
      raw[11:4] = {4{ap}};
      raw[1:0]  = kind;
      return raw;
   endfunction

   // Queues one walk, mostly well formed; returns the number of items that do real work.
   function automatic int queue_random_walk();
      int          pick;
      logic [31:0] d1;
      logic [31:0] d2;
      pick = $urandom_range(99);
      d1   = $urandom();
      d2   = $urandom();
      if (pick < 6) begin
         req_backlog.push_back(table_word(d1));
         return 0;
      end
      req_backlog.push_back(walk_request($urandom(), 1'($urandom_range(1)),
                                         1'($urandom_range(1))));
      // Some requests are abandoned so the next request cuts the walk short.
      if (pick < 12) return 1;
      pick = $urandom_range(99);
      if (pick < 45)      d1[1:0] = DESC_COARSE;
      else if (pick < 80) d1[1:0] = DESC_SECTION;
      else if (pick < 90) d1[1:0] = DESC_FAULT;
      else                d1[1:0] = DESC_FINE;
      req_backlog.push_back(table_word(d1));
      if (d1[1:0] != DESC_COARSE) return 2;
      if ($urandom_range(19) == 0) return 2;
      pick = $urandom_range(99);
      if (pick < 40)      d2[1:0] = DESC_LARGE;
      else if (pick < 80) d2[1:0] = DESC_SMALL;
      else if (pick < 90) d2[1:0] = DESC_FAULT;
      else                d2[1:0] = DESC_FINE;
      req_backlog.push_back(table_word(d2));
      return 3;
   endfunction

   task automatic csr_write(input logic [CsrIndexWidth-1:0] idx, input logic [CsrDataWidth-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic program_walker(input logic [TableBaseWidth-1:0] base, input logic [1:0] rs);
      logic [CsrDataWidth-1:0] word;
      word      = CsrDataWidth'($urandom());
      word[1:0] = rs;
      csr_write(CSR_TABLE_BASE, base);
      csr_write(CSR_ROM_SYS, word);
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (req_backlog.size() != 0 || rsp_due.size() != 0);
   endtask

   initial begin
      int counted;
      do @(negedge clock); while (reset);

      program_walker(18'h3ffff, 2'b00);
      @(negedge clock);
      req_backlog.push_back(table_word($urandom()));
      req_backlog.push_back(walk_request(32'hffff_ffff, 1'b1, 1'b1));
      req_backlog.push_back(table_word(perm_word(DESC_FAULT, AP_FULL)));
      req_backlog.push_back(walk_request(32'h0000_0000, 1'b0, 1'b0));
      req_backlog.push_back(table_word(perm_word(DESC_SECTION, AP_FULL)));
      req_backlog.push_back(walk_request(32'hffff_ffff, 1'b1, 1'b0));
      req_backlog.push_back(table_word(perm_word(DESC_SECTION, AP_PRIV)));
      req_backlog.push_back(walk_request($urandom(), 1'b0, 1'b0));
      req_backlog.push_back(table_word(perm_word(DESC_SECTION, AP_USER_READ)));
      req_backlog.push_back(walk_request($urandom(), 1'b0, 1'b1));
      req_backlog.push_back(table_word({30'h3fff_ffff, DESC_COARSE}));
      req_backlog.push_back(table_word(perm_word(DESC_LARGE, AP_FULL)));
      req_backlog.push_back(walk_request($urandom(), 1'b1, 1'b0));
      req_backlog.push_back(table_word({30'h0, DESC_COARSE}));
      req_backlog.push_back(table_word(perm_word(DESC_SMALL, AP_NONE)));
      req_backlog.push_back(walk_request($urandom(), 1'b0, 1'b1));
      req_backlog.push_back(table_word(perm_word(DESC_COARSE, AP_FULL)));
      req_backlog.push_back(table_word(perm_word(DESC_FAULT, AP_FULL)));
      req_backlog.push_back(walk_request($urandom(), 1'b1, 1'b1));
      req_backlog.push_back(table_word(perm_word(DESC_COARSE, AP_FULL)));
      req_backlog.push_back(table_word(perm_word(DESC_FINE, AP_FULL)));
      req_backlog.push_back(walk_request($urandom(), 1'b0, 1'b0));
      req_backlog.push_back(table_word(perm_word(DESC_FINE, AP_FULL)));
      // A request in the middle of a walk drops the walk in progress.
      req_backlog.push_back(walk_request($urandom(), 1'b0, 1'b1));
      req_backlog.push_back(walk_request($urandom(), 1'b1, 1'b1));
      req_backlog.push_back(table_word(perm_word(DESC_SECTION, AP_PRIV)));
      req_backlog.push_back(table_word($urandom()));
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: program_walker(18'h00000, 2'b00);
            1: program_walker(TableBaseWidth'($urandom()), 2'b01);
            2: program_walker(18'h3ffff, 2'b10);
            3: program_walker(TableBaseWidth'($urandom()), 2'b11);
            4: begin
               csr_write(CSR_SPARE_A, CsrDataWidth'($urandom()));
               csr_write(CSR_SPARE_B, CsrDataWidth'($urandom()));
               program_walker(TableBaseWidth'($urandom()), 2'($urandom_range(3)));
            end
            default: program_walker(18'h00000, 2'($urandom_range(3)));
         endcase
         @(negedge clock);
         if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = IdlePct;
            recv_idle_pct = IdlePct;
         end
         if (phase == 3) begin
            // With R and S both set, AP zero grants privileged access only.
            req_backlog.push_back(walk_request($urandom(), 1'b0, 1'b0));
            req_backlog.push_back(table_word(perm_word(DESC_SECTION, AP_NONE)));
            req_backlog.push_back(walk_request($urandom(), 1'b1, 1'b1));
            req_backlog.push_back(table_word(perm_word(DESC_SECTION, AP_NONE)));
            // Hold the receiver off long enough for the block to back up into its input.
            rsp_stall_left = 400;
         end
         counted = 0;
         while (counted < 125) counted += queue_random_walk();
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0 && rsp_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mtw_pkg.sv
rtl/core/mtw_walker.sv
rtl/core/mmu_two_level_table_walk.sv
tb/tb_top.sv
